>>> rtl/sisa_pkg.sv
// Shared constants, types and the microcode program of the sampled inverse suffix array.
package sisa_pkg;

  // Table geometry.
  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned VALUE_BITS  = 12;
  localparam int unsigned ADDR_BITS   = $clog2(MAX_ENTRIES);

  // Field and register widths.
  localparam int unsigned KIND_BITS    = 2;
  localparam int unsigned POS_BITS     = 12;
  localparam int unsigned RATE_BITS    = 9;
  localparam int unsigned COUNT_BITS   = 13;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CNT_BITS     = RATE_BITS;
  localparam int unsigned DIV_STEPS    = POS_BITS;
  localparam int unsigned PC_BITS      = 4;

  // Register reset values.
  localparam logic [RATE_BITS-1:0]  RATE_RESET  = RATE_BITS'(32);
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(4096);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLING_RATE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_COUNT   = 2'd1;

  // Request kinds.
  localparam logic [KIND_BITS-1:0] KIND_SUFFIX = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_NEXT   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_RES_OOR  = 4'd2,
    OP_DIV_STEP = 4'd3,
    OP_SAMP_WR  = 4'd4,
    OP_NEXT_WR  = 4'd5,
    OP_SAMP_RD  = 4'd6,
    OP_RES_SAMP = 4'd7,
    OP_WALK_S   = 4'd8,
    OP_WALK_N   = 4'd9,
    OP_RES_NEXT = 4'd10,
    OP_EMIT     = 4'd11
  } dp_op_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NO_INPUT    = 4'd2,
    C_KIND_NEXT   = 4'd3,
    C_KIND_UNUSED = 4'd4,
    C_OUT_RANGE   = 4'd5,
    C_DIV_MORE    = 4'd6,
    C_KIND_QUERY  = 4'd7,
    C_WALK_ZERO   = 4'd8,
    C_WALK_MORE   = 4'd9,
    C_OUT_BUSY    = 4'd10
  } cond_e;

  typedef struct packed {
    dp_op_e               op;
    cond_e                cond;
    logic [PC_BITS-1:0]   target;
  } ctrl_word_t;

  // Flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_valid;
    logic kind_next;
    logic kind_unused;
    logic kind_query;
    logic out_range;
    logic div_more;
    logic walk_zero;
    logic walk_more;
    logic out_busy;
  } status_t;

  // Program labels.
  localparam logic [PC_BITS-1:0] L_IDLE = 4'd0;
  localparam logic [PC_BITS-1:0] L_DIV  = 4'd4;
  localparam logic [PC_BITS-1:0] L_NXT  = 4'd7;
  localparam logic [PC_BITS-1:0] L_QRY  = 4'd8;
  localparam logic [PC_BITS-1:0] L_WALK = 4'd11;
  localparam logic [PC_BITS-1:0] L_EMIT = 4'd13;

  // The microcode program. A word jumps to its target when its condition
  // holds and otherwise falls through to the next address.
  function automatic ctrl_word_t ucode_rom(input logic [PC_BITS-1:0] addr);
    ctrl_word_t w;
    unique case (addr)
      4'd0:  w = '{OP_ACCEPT,   C_NO_INPUT,    L_IDLE};
      4'd1:  w = '{OP_NOP,      C_KIND_NEXT,   L_NXT};
      4'd2:  w = '{OP_NOP,      C_KIND_UNUSED, L_IDLE};
      4'd3:  w = '{OP_RES_OOR,  C_OUT_RANGE,   L_EMIT};
      4'd4:  w = '{OP_DIV_STEP, C_DIV_MORE,    L_DIV};
      4'd5:  w = '{OP_NOP,      C_KIND_QUERY,  L_QRY};
      4'd6:  w = '{OP_SAMP_WR,  C_ALWAYS,      L_IDLE};
      4'd7:  w = '{OP_NEXT_WR,  C_ALWAYS,      L_IDLE};
      4'd8:  w = '{OP_SAMP_RD,  C_NEVER,       L_IDLE};
      4'd9:  w = '{OP_RES_SAMP, C_WALK_ZERO,   L_EMIT};
      4'd10: w = '{OP_WALK_S,   C_NEVER,       L_IDLE};
      4'd11: w = '{OP_WALK_N,   C_WALK_MORE,   L_WALK};
      4'd12: w = '{OP_RES_NEXT, C_NEVER,       L_IDLE};
      4'd13: w = '{OP_EMIT,     C_OUT_BUSY,    L_EMIT};
      4'd14: w = '{OP_NOP,      C_ALWAYS,      L_IDLE};
      4'd15: w = '{OP_NOP,      C_ALWAYS,      L_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/sisa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sisa_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sisa_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module sisa_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sisa_pkg::status_t status_i,
  output sisa_pkg::dp_op_e  op_o
);
  import sisa_pkg::*;

  logic [PC_BITS-1:0] pc_q, pc_d;
  ctrl_word_t         word;
  logic               take;

  assign word = ucode_rom(pc_q);
  assign op_o = word.op;

  // Evaluate the jump condition of the current word.
  always_comb begin
    unique case (word.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !status_i.in_valid;
      C_KIND_NEXT:   take = status_i.kind_next;
      C_KIND_UNUSED: take = status_i.kind_unused;
      C_OUT_RANGE:   take = status_i.out_range;
      C_DIV_MORE:    take = status_i.div_more;
      C_KIND_QUERY:  take = status_i.kind_query;
      C_WALK_ZERO:   take = status_i.walk_zero;
      C_WALK_MORE:   take = status_i.walk_more;
      C_OUT_BUSY:    take = status_i.out_busy;
      default:       take = 1'b0;
    endcase
  end

  assign pc_d = take ? word.target : pc_q + 1'b1;

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= L_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> rtl/sisa_dpath.sv
// Datapath: request registers, shift-subtract divider, walk counter, tables and result register.
module sisa_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sisa_pkg::dp_op_e                    op_i,
  output sisa_pkg::status_t                   status_o,
  input  logic [sisa_pkg::RATE_BITS-1:0]      rate_i,
  input  logic [sisa_pkg::COUNT_BITS-1:0]     count_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sisa_pkg::KIND_BITS-1:0]      kind_i,
  input  logic [sisa_pkg::POS_BITS-1:0]       position_i,
  input  logic [sisa_pkg::VALUE_BITS-1:0]     entry_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sisa_pkg::VALUE_BITS-1:0]     inverse_value_o,
  output logic                                out_of_range_o
);
  import sisa_pkg::*;

  logic [KIND_BITS-1:0]  kind_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [POS_BITS-1:0]   quo_q;
  logic [RATE_BITS-1:0]  rem_q;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] res_q;
  logic                  res_oor_q;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_oor_q;
  logic                  out_free;

  logic [RATE_BITS:0]    trial, diff;
  logic                  fits;
  logic [RATE_BITS-1:0]  rem_step;
  logic [POS_BITS-1:0]   quo_step;

  logic                  samp_we, samp_re, next_we, next_re;
  logic [ADDR_BITS-1:0]  samp_addr, next_waddr, next_raddr;
  logic [VALUE_BITS-1:0] samp_rdata, next_rdata;

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  assign trial    = {rem_q, quo_q[POS_BITS-1]};
  assign fits     = trial >= {1'b0, rate_i};
  assign diff     = trial - {1'b0, rate_i};
  assign rem_step = fits ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
  assign quo_step = {quo_q[POS_BITS-2:0], fits};

  assign in_ready_o = (op_i == OP_ACCEPT);
  assign out_free   = !out_valid_q || out_ready_i;

  // Flags for the sequencer.
  always_comb begin
    status_o.in_valid    = in_valid_i;
    status_o.kind_next   = (kind_q == KIND_NEXT);
    status_o.kind_unused = (kind_q == KIND_UNUSED);
    status_o.kind_query  = (kind_q == KIND_QUERY);
    status_o.out_range   = (kind_q == KIND_QUERY) && ({1'b0, pos_q} >= count_i);
    status_o.div_more    = (cnt_q != CNT_BITS'(1));
    status_o.walk_zero   = (cnt_q == '0);
    status_o.walk_more   = (cnt_q != '0);
    status_o.out_busy    = out_valid_q && !out_ready_i;
  end

  // Table access. The sample slot is the quotient; the walk follows read data.
  assign samp_addr  = quo_q[ADDR_BITS-1:0];
  assign samp_we    = (op_i == OP_SAMP_WR) && (rem_q == '0);
  assign samp_re    = (op_i == OP_SAMP_RD);
  assign next_waddr = pos_q[ADDR_BITS-1:0];
  assign next_we    = (op_i == OP_NEXT_WR);
  assign next_re    = (op_i == OP_WALK_S) || ((op_i == OP_WALK_N) && (cnt_q != '0));
  assign next_raddr = (op_i == OP_WALK_S) ? samp_rdata[ADDR_BITS-1:0]
                                          : next_rdata[ADDR_BITS-1:0];

  sisa_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (samp_we),
    .waddr_i (samp_addr),
    .wdata_i (pos_q),
    .re_i    (samp_re),
    .raddr_i (samp_addr),
    .rdata_o (samp_rdata)
  );

  sisa_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (val_q),
    .re_i    (next_re),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  // Step counter shared by the divider and the pointer walk.
  always_comb begin
    cnt_d = cnt_q;
    unique case (op_i)
      OP_ACCEPT:   if (in_valid_i) cnt_d = CNT_BITS'(DIV_STEPS);
      OP_DIV_STEP: cnt_d = cnt_q - 1'b1;
      OP_SAMP_RD:  cnt_d = rem_q;
      OP_WALK_S:   cnt_d = cnt_q - 1'b1;
      OP_WALK_N:   if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      default:     cnt_d = cnt_q;
    endcase
  end

  // The output register takes a result when it is empty or being emptied.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((op_i == OP_EMIT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture and divider registers.
  always_ff @(posedge clk_i) begin
    if ((op_i == OP_ACCEPT) && in_valid_i) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= entry_value_i;
      quo_q  <= (kind_i == KIND_QUERY) ? position_i : entry_value_i;
      rem_q  <= '0;
    end else if (op_i == OP_DIV_STEP) begin
      quo_q  <= quo_step;
      rem_q  <= rem_step;
    end
  end

  // Result staging.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_RES_OOR: begin
        res_q     <= '0;
        res_oor_q <= 1'b1;
      end
      OP_RES_SAMP: begin
        res_q     <= samp_rdata;
        res_oor_q <= 1'b0;
      end
      OP_RES_NEXT: begin
        res_q     <= next_rdata;
        res_oor_q <= 1'b0;
      end
      default: begin
        res_q     <= res_q;
        res_oor_q <= res_oor_q;
      end
    endcase
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if ((op_i == OP_EMIT) && out_free) begin
      out_value_q <= res_q;
      out_oor_q   <= res_oor_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign inverse_value_o = out_value_q;
  assign out_of_range_o  = out_oor_q;

endmodule

>>> rtl/sampled_inverse_suffix_array.sv
// Top level: configuration registers, microcode sequencer and datapath.
// One request at a time. An in-range query divides position by the rate, one quotient bit
// per cycle, reads the sample, then follows position mod rate next pointers, one
// next-pointer read per cycle. An out-of-range query skips the divider, a suffix load is
// divided too, a next-pointer load is written without the divider; output stalls add.
// Reset (asynchronous, active low) sets rate 32 and count 4096; tables are not cleared.
module sampled_inverse_suffix_array (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sisa_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [sisa_pkg::COUNT_BITS-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sisa_pkg::KIND_BITS-1:0]      kind_i,
  input  logic [sisa_pkg::POS_BITS-1:0]       position_i,
  input  logic [sisa_pkg::VALUE_BITS-1:0]     entry_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sisa_pkg::VALUE_BITS-1:0]     inverse_value_o,
  output logic                                out_of_range_o
);
  import sisa_pkg::*;

  logic [RATE_BITS-1:0]  rate_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [RATE_BITS-1:0]  eff_rate;
  dp_op_e                op;
  status_t               status;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SAMPLING_RATE) begin
        rate_q <= cfg_data_i[RATE_BITS-1:0];
      end else if (cfg_index_i == CFG_ENTRY_COUNT) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // A rate of zero behaves as one.
  assign eff_rate = (rate_q == '0) ? RATE_BITS'(1) : rate_q;

  sisa_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  sisa_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .rate_i          (eff_rate),
    .count_i         (count_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .entry_value_i   (entry_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .inverse_value_o (inverse_value_o),
    .out_of_range_o  (out_of_range_o)
  );

endmodule

>>> rtl/sisa_checker.sv
// Port-level checks on the sampled inverse suffix array, bound to the top level.
module sisa_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [sisa_pkg::VALUE_BITS-1:0]     inverse_value_o,
  input logic                                out_of_range_o
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(inverse_value_o) && $stable(out_of_range_o))
    else $error("stalled result changed");

  // An out-of-range answer carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> inverse_value_o == '0)
    else $error("out-of-range result with non-zero value");

  // Requests are handled one at a time: no request is taken in the cycle after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while the previous one is in progress");

endmodule

bind sampled_inverse_suffix_array sisa_checker u_sisa_checker (.*);

>>> verif/sampled_inverse_suffix_array_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench that builds sampled inverse suffix tables and checks query results.
module sampled_inverse_suffix_array_tb;
  import sisa_pkg::*;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 40;
  localparam int END_CYCLES    = 64;
  localparam int MAX_BUILD     = 64;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [POS_BITS-1:0]   pos;
    logic [VALUE_BITS-1:0] value;
  } request_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] inverse;
    logic                  oor;
  } inverse_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COUNT_BITS-1:0]   cfg_data  = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_BITS-1:0]  in_kind  = '0;
  logic [POS_BITS-1:0]   in_pos   = '0;
  logic [VALUE_BITS-1:0] in_value = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VALUE_BITS-1:0] inverse_value;
  logic                  out_of_range;

  sampled_inverse_suffix_array dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (in_kind),
    .position_i      (in_pos),
    .entry_value_i   (in_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .inverse_value_o (inverse_value),
    .out_of_range_o  (out_of_range)
  );

  always #10 clk = ~clk;

  // Request queue and the expected inverse values still owed by the block.
  request_t pending_requests[$];
  inverse_t expected_inverses[$];
  request_t next_req;
  inverse_t want;

  int unsigned n_issued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_queries  = 0;
  int unsigned n_results  = 0;
  int unsigned n_oor      = 0;
  int unsigned n_errors   = 0;
  int unsigned n_phases   = 0;
  int unsigned quiet_cycles = 0;

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;

  // Predictor state, updated at each accepted request and register write.
  logic [RATE_BITS-1:0]  rate_reg  = RATE_RESET;
  logic [COUNT_BITS-1:0] count_reg = COUNT_RESET;
  logic [VALUE_BITS-1:0] slot_tab [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] next_tab [MAX_ENTRIES];

  // Stimulus-side picture of the tables, so that queries only read written entries.
  logic [RATE_BITS-1:0]  shadow_rate  = RATE_RESET;
  logic [COUNT_BITS-1:0] shadow_count = COUNT_RESET;
  logic [VALUE_BITS-1:0] shadow_slot [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] shadow_next [MAX_ENTRIES];
  bit                    shadow_slot_ok [MAX_ENTRIES];
  bit                    shadow_next_ok [MAX_ENTRIES];
  int                    perm [MAX_BUILD];
  int                    build_n = 1;

  // Work out the result of one accepted request and advance the predicted tables.
  task automatic predict_lookup(input logic [KIND_BITS-1:0] k, input logic [POS_BITS-1:0] p,
                                input logic [VALUE_BITS-1:0] v);
    int unsigned step;
    int unsigned cur;
    int unsigned hops;
    inverse_t    e;
    step = (rate_reg == 0) ? 1 : rate_reg;
    if (k == KIND_SUFFIX) begin
      if (v % step == 0) slot_tab[v / step] = p;
    end else if (k == KIND_NEXT) begin
      next_tab[p] = v;
    end else if (k == KIND_QUERY) begin
      e.oor     = (p >= count_reg);
      e.inverse = '0;
      if (!e.oor) begin
        cur = slot_tab[p / step];
        for (hops = p % step; hops != 0; hops--) cur = next_tab[cur];
        e.inverse = VALUE_BITS'(cur);
      end
      expected_inverses.push_back(e);
      n_queries++;
    end
  endtask

  function automatic int unsigned shadow_step();
    return (shadow_rate == 0) ? 1 : shadow_rate;
  endfunction

  // True when a query for q reads only table entries that have been written.
  function automatic bit walk_safe(input logic [POS_BITS-1:0] q);
    int unsigned step;
    int unsigned cur;
    int unsigned hops;
    step = shadow_step();
    if (!shadow_slot_ok[q / step]) return 1'b0;
    cur = shadow_slot[q / step];
    for (hops = q % step; hops != 0; hops--) begin
      if (!shadow_next_ok[cur]) return 1'b0;
      cur = shadow_next[cur];
    end
    return 1'b1;
  endfunction

  task automatic push_request(input logic [KIND_BITS-1:0] k, input logic [POS_BITS-1:0] p,
                              input logic [VALUE_BITS-1:0] v);
    request_t    r;
    int unsigned step;
    step    = shadow_step();
    r.kind  = k;
    r.pos   = p;
    r.value = v;
    if (k == KIND_SUFFIX && v % step == 0) begin
      shadow_slot[v / step]    = p;
      shadow_slot_ok[v / step] = 1'b1;
    end else if (k == KIND_NEXT) begin
      shadow_next[p]    = v;
      shadow_next_ok[p] = 1'b1;
    end
    pending_requests.push_back(r);
    n_issued++;
  endtask

  // Queries that would read an unwritten entry are moved onto the built range.
  task automatic push_query(input logic [POS_BITS-1:0] q);
    int tries;
    tries = 0;
    while (q < shadow_count && !walk_safe(q) && tries < 64) begin
      q = POS_BITS'($urandom_range(build_n - 1, 0));
      tries++;
    end
    if (q < shadow_count && !walk_safe(q)) q = '0;
    push_request(KIND_QUERY, q, VALUE_BITS'($urandom));
  endtask

  // Load a shuffled suffix array of n positions and a next-pointer table inside it.
  task automatic build_tables(input int n);
    int i;
    int j;
    int tmp;
    build_n = n;
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i, 0);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (i = 0; i < n; i++) begin
      push_request(KIND_SUFFIX, POS_BITS'(i), VALUE_BITS'(perm[i]));
      push_request(KIND_NEXT, POS_BITS'(i), VALUE_BITS'($urandom_range(n - 1, 0)));
    end
  endtask

  // Mostly well-formed queries and reloads, with some noise loads and unused kinds.
  task automatic mix_requests(input int n_items);
    int          done;
    int unsigned dice;
    int unsigned step;
    int          p;
    done = 0;
    step = shadow_step();
    if (shadow_count != 0 && shadow_count <= MAX_ENTRIES) begin
      push_query(POS_BITS'(shadow_count - 1));
      if (shadow_count < MAX_ENTRIES) push_query(POS_BITS'(shadow_count));
    end
    while (done < n_items) begin
      dice = $urandom_range(99);
      if (dice < 60) begin
        push_query(POS_BITS'($urandom_range(build_n - 1, 0)));
      end else if (dice < 68) begin
        push_query(POS_BITS'($urandom));
      end else if (dice < 72) begin
        if (shadow_count < MAX_ENTRIES) push_query(POS_BITS'($urandom_range(4095, shadow_count)));
        else push_query(POS_BITS'($urandom));
      end else if (dice < 80) begin
        p = $urandom_range(build_n - 1, 0);
        push_request(KIND_SUFFIX, POS_BITS'(p), VALUE_BITS'(perm[p]));
      end else if (dice < 85) begin
        push_request(KIND_NEXT, POS_BITS'($urandom_range(build_n - 1, 0)),
                     VALUE_BITS'($urandom_range(build_n - 1, 0)));
      end else if (dice < 93) begin
        if ($urandom_range(1, 0)) begin
          push_request(KIND_SUFFIX, POS_BITS'($urandom), VALUE_BITS'($urandom));
        end else begin
          push_request(KIND_SUFFIX, POS_BITS'($urandom),
                       VALUE_BITS'(step * $urandom_range(4095 / step, 0)));
        end
      end else if (dice < 98) begin
        push_request(KIND_NEXT, POS_BITS'($urandom), VALUE_BITS'($urandom));
      end else begin
        // An unused kind is dropped by the block, so it does not count.
        push_request(KIND_UNUSED, POS_BITS'($urandom), VALUE_BITS'($urandom));
        done--;
      end
      done++;
    end
  endtask

  // Wait until every request is taken and every result is back, then let the block finish.
  task automatic settle(input int cycles);
    while (n_accepted != n_issued || expected_inverses.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COUNT_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SAMPLING_RATE) shadow_rate = data[RATE_BITS-1:0];
    else if (idx == CFG_ENTRY_COUNT) shadow_count = data;
  endtask

  task automatic run_phase(input logic [COUNT_BITS-1:0] rate_data,
                           input logic [COUNT_BITS-1:0] count_data, input int n, input int mixes,
                           input int unsigned in_pct, input int unsigned out_pct);
    settle(SETTLE_CYCLES);
    set_reg(CFG_SAMPLING_RATE, rate_data);
    set_reg(CFG_ENTRY_COUNT, count_data);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    build_tables(n);
    mix_requests(mixes);
    n_phases++;
  endtask

  // Driver: presents pending requests, with random idle bursts between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap == 0 && $urandom_range(99) < in_idle_pct) in_gap = $urandom_range(16, 1);
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        next_req = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_kind  <= next_req.kind;
        in_pos   <= next_req.pos;
        in_value <= next_req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes and requests, checks results, stalls the output.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SAMPLING_RATE) rate_reg = cfg_data[RATE_BITS-1:0];
        else if (cfg_index == CFG_ENTRY_COUNT) count_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (out_of_range) n_oor++;
        if (expected_inverses.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("unexpected result: inverse %0d out_of_range %0b", inverse_value,
                     out_of_range);
          end
        end else begin
          want = expected_inverses.pop_front();
          if (want.inverse !== inverse_value || want.oor !== out_of_range) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result %0d: expected inverse %0d out_of_range %0b, got %0d %0b",
                       n_results, want.inverse, want.oor, inverse_value, out_of_range);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        n_accepted++;
        predict_lookup(in_kind, in_pos, in_value);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        out_stall = $urandom_range(16, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("** sampled_inverse_suffix_array: FAILED **");
      $finish;
    end
  end

  // Stimulus: a directed opening at the reset settings, then phases of register settings.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 25;
    out_idle_pct = 25;
    // Extreme positions and values, a two-entry pointer cycle, and loads that store nothing.
    push_request(KIND_SUFFIX, 12'd4095, 12'd0);
    push_request(KIND_SUFFIX, 12'd0, 12'd4064);
    push_request(KIND_SUFFIX, 12'd7, 12'd33);
    push_request(KIND_NEXT, 12'd4095, 12'd0);
    push_request(KIND_NEXT, 12'd0, 12'd4095);
    push_request(KIND_QUERY, 12'd0, 12'd4095);
    push_query(12'd1);
    push_query(12'd31);
    push_query(12'd4064);
    push_query(12'd4095);
    push_request(KIND_UNUSED, 12'd4095, 12'd4095);
    push_query(12'd2);
    push_request(KIND_SUFFIX, 12'd4095, 12'd4095);
    push_query(12'd0);
    build_tables(32);
    mix_requests(110);
    n_phases++;

    run_phase(13'd1, 13'd4096, 24, 100, 0, 0);
    run_phase(13'd256, 13'h1FFF, 48, 110, 40, 10);
    // The spare indexes must leave both registers alone.
    settle(SETTLE_CYCLES);
    set_reg(CFG_SPARE_A, 13'h1FFF);
    set_reg(CFG_SPARE_B, 13'h0AAA);
    run_phase(13'h1E00, 13'd0, 16, 80, 10, 40);
    run_phase(13'h01FF, 13'd100, 40, 110, 25, 25);
    run_phase(13'd7, 13'd1, 12, 90, 15, 30);
    run_phase(13'h0403, 13'd37, 32, 120, 0, 0);

    settle(END_CYCLES);
    $display("Ran %0d register settings (rates 0 to 511, counts 0 to 8191), %0d requests taken.",
             n_phases, n_accepted);
    $display("Checked %0d results for %0d queries, %0d out of range; %0d errors.", n_results,
             n_queries, n_oor, n_errors);
    if (n_errors == 0 && expected_inverses.size() == 0) begin
      $display("** sampled_inverse_suffix_array: PASSED **");
    end else begin
      $display("** sampled_inverse_suffix_array: FAILED **");
    end
    $finish;
  end

endmodule
